// ----- design/rfc_pkg.sv -----
// Package for the response frame checker: request types, phase encoding
// and queue sizing. No dependencies.
package rfc_pkg;

    localparam logic [7:0] SYNC_ZERO   = 8'h00;
    localparam logic [7:0] SYNC_MARK   = 8'hFF;
    localparam logic [7:0] POSTAMBLE   = 8'h00;
    localparam int         QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_SYNC3 = 3'd2,
        PH_LEN   = 3'd3,
        PH_LCS   = 3'd4,
        PH_DATA  = 3'd5,
        PH_DCS   = 3'd6,
        PH_POST  = 3'd7
    } phase_t;

    typedef enum logic {
        ST_OK  = 1'b0,
        ST_BAD = 1'b1
    } frame_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic [5:0] payload_limit;
    } in_req_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [5:0] payload_index;
        logic       frame_done;
        logic       frame_status;
        logic [5:0] frame_length;
    } out_req_t;

endpackage

// ----- design/rfc_front.sv -----
// Front end of the response frame checker: frame parser state machine that
// classifies each byte and builds its result request. Depends on rfc_pkg.
module rfc_front #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  rfc_pkg::in_req_t in_req,
    output rfc_pkg::out_req_t res
);
    import rfc_pkg::*;

    localparam logic [8:0] BUF_LIMIT = 9'(FRAME_BUFFER_BYTES);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [5:0] count_reg, count_next;
    logic [5:0] limit_reg, limit_next;

    logic [7:0] b;
    logic       lcs_bad;
    logic       data_last;

    assign b         = in_req.rx_byte;
    assign lcs_bad   = ((len_reg + b) != 8'd0)
                     || (({1'b0, len_reg} + 9'd2) > BUF_LIMIT)
                     || (len_reg > {2'b00, limit_reg});
    assign data_last = ({1'b0, count_reg} + 7'd1) >= {1'b0, len_reg[6:0]}
                     || len_reg[7];

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        if (in_req.frame_start) begin
            limit_next = in_req.payload_limit;
            len_next   = 8'd0;
            sum_next   = 8'd0;
            count_next = 6'd0;
            phase_next = (b != SYNC_ZERO) ? PH_IDLE : PH_SYNC2;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_SYNC2: begin
                    phase_next = (b != SYNC_ZERO) ? PH_IDLE : PH_SYNC3;
                end
                PH_SYNC3: begin
                    phase_next = (b != SYNC_MARK) ? PH_IDLE : PH_LEN;
                end
                PH_LEN: begin
                    len_next   = b;
                    phase_next = PH_LCS;
                end
                PH_LCS: begin
                    if (lcs_bad) begin
                        phase_next = PH_IDLE;
                    end else begin
                        sum_next   = 8'd0;
                        count_next = 6'd0;
                        phase_next = (len_reg == 8'd0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_DATA: begin
                    sum_next = sum_reg + b;
                    if (data_last) begin
                        phase_next = PH_DCS;
                    end else begin
                        count_next = count_reg + 6'd1;
                    end
                end
                PH_DCS: begin
                    phase_next = ((sum_reg + b) != 8'd0) ? PH_IDLE : PH_POST;
                end
                PH_POST: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res = '0;
        if (in_req.frame_start) begin
            if (b != SYNC_ZERO) begin
                res.frame_done   = 1'b1;
                res.frame_status = ST_BAD;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE, PH_LEN: begin
                end
                PH_SYNC2: begin
                    res.frame_done   = (b != SYNC_ZERO);
                    res.frame_status = (b != SYNC_ZERO);
                end
                PH_SYNC3: begin
                    res.frame_done   = (b != SYNC_MARK);
                    res.frame_status = (b != SYNC_MARK);
                end
                PH_LCS: begin
                    res.frame_done   = lcs_bad;
                    res.frame_status = lcs_bad;
                end
                PH_DATA: begin
                    res.payload_byte  = b;
                    res.payload_valid = 1'b1;
                    res.payload_index = count_reg;
                end
                PH_DCS: begin
                    res.frame_done   = ((sum_reg + b) != 8'd0);
                    res.frame_status = ((sum_reg + b) != 8'd0);
                end
                PH_POST: begin
                    res.frame_done   = 1'b1;
                    res.frame_status = (b != POSTAMBLE);
                    res.frame_length = (b != POSTAMBLE) ? 6'd0 : len_reg[5:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            count_reg <= 6'd0;
            limit_reg <= 6'd0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            limit_reg <= limit_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && res.frame_done |=> phase_reg == PH_IDLE)
        else $error("phase not idle after frame_done");

    a_payload_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && res.payload_valid |-> phase_reg == PH_DATA && !in_req.frame_start)
        else $error("payload request outside data phase");

    a_status_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res.frame_status |-> res.frame_done && !res.payload_valid)
        else $error("bad status without frame_done");

    a_data_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> {2'b00, count_reg} < len_reg)
        else $error("payload index past declared length");

endmodule

// ----- design/rfc_queue.sv -----
// Short result queue between the parser front end and the output stage.
// Depends on rfc_pkg.
module rfc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rfc_pkg::out_req_t push_req,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output rfc_pkg::out_req_t head_req
);
    import rfc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);

    out_req_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_req  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[PW-1:0])
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + (PW + 1)'(1))
        else $error("push lost");

endmodule

// ----- design/response_frame_checker_core.sv -----
// Top level of the response frame checker: parser front end, result queue
// and registered output stage. Depends on rfc_pkg, rfc_front, rfc_queue.
//
//  channel | ports                     | moves
//  input   | s_valid s_ready s_data    | one frame byte per request
//  result  | m_valid m_ready m_data    | one result per accepted byte
//
// One byte per cycle while s_ready is high; each result is queued, then
// registered. The parser state machine handles each byte in the cycle it
// is accepted. A 4-entry queue plus the output register absorb result
// stalls; s_ready drops only when the queue is full.
// Reset (aresetn low, synchronous) empties the queue and idles the parser.
module response_frame_checker_core #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rfc_pkg::in_req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rfc_pkg::out_req_t m_data
);
    import rfc_pkg::*;

    out_req_t front_res;
    out_req_t head_req;
    logic     q_full, q_not_empty, q_pop, in_fire;
    logic     m_valid_reg, m_valid_next;
    out_req_t m_data_reg;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    rfc_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_req  (s_data),
        .res     (front_res)
    );

    rfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_req  (front_res),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_req  (head_req)
    );

    assign q_pop        = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid_next = q_pop || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= head_req;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !m_valid_reg || m_ready)
        else $error("output register overwritten");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_ready)
        else $error("input taken while queue full");

    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(q_not_empty))
        else $error("result shown without queued request");

endmodule
